### rtl/core/fbnp_pkg.sv
// Package for the FASTQ base nibble packer: phase codes, the base code table
// and the item type passed between the input register and the parser.
// No dependencies.
package fbnp_pkg;

  // Parser phases within one FASTQ record.
  localparam logic [2:0] PH_HEADER = 3'd0;
  localparam logic [2:0] PH_SEQ    = 3'd1;
  localparam logic [2:0] PH_SEPNL  = 3'd2;
  localparam logic [2:0] PH_PLUS   = 3'd3;
  localparam logic [2:0] PH_QUAL   = 3'd4;

  localparam logic [7:0] NEWLINE = 8'd10;

  // Code for any byte that is not a known base.
  localparam logic [2:0] CODE_OTHER = 3'd4;

  // One registered input item.
  typedef struct packed {
    logic       valid;
    logic [7:0] data;
  } fbnp_item_t;

  // Map one text byte to its 3-bit base code.
  function automatic logic [2:0] base_code(input logic [7:0] b);
    logic [2:0] code;
    case (b)
      8'd0, 8'd1, 8'd2, 8'd3: code = b[2:0];
      "A", "a":                code = 3'd0;
      "C", "c":                code = 3'd1;
      "G", "g":                code = 3'd2;
      "T", "t", "U", "u":      code = 3'd3;
      default:                 code = CODE_OTHER;
    endcase
    return code;
  endfunction

endpackage

### rtl/core/fbnp_if.sv
// Valid/ready channel interfaces for the FASTQ base nibble packer.
// Input channel carries one text byte; output channel one packed byte.
interface fbnp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

interface fbnp_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] packed_byte;
  logic       last_of_read;

  modport source (output valid, output packed_byte, output last_of_read, input ready);
  modport sink   (input valid, input packed_byte, input last_of_read, output ready);
endinterface

### rtl/core/fastq_base_nibble_packer_core.sv
// FASTQ base nibble packer, top level. Takes FASTQ text one byte per item,
// skips each header line, packs read_length bases two to a byte (first base
// in bits 3..0, codes A=0 C=1 G=2 T/U=3, bytes 0..3 as themselves, other 4),
// flags the last packed byte of each read, then skips the sequence newline,
// the '+' line and read_length quality bytes plus their newline by count.
// A new input byte is accepted each cycle while the output is not stalled;
// an item passes the input register and then the parser's result register,
// from which the packed byte that a completing base byte yields goes out.
// read_length (reset 150) is written through cfg_write_en / cfg_write_data;
// a value of 0 acts as 1, a value above MAX_READ_LEN acts as MAX_READ_LEN.
// Depends on fbnp_pkg, fbnp_if, fbnp_in_stage and fbnp_parser.
module fastq_base_nibble_packer_core #(
  parameter int MAX_READ_LEN = 65535
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write_en,
  input  logic [15:0] cfg_write_data,
  fbnp_in_if.sink     in_ch,
  fbnp_out_if.source  out_ch
);
  import fbnp_pkg::*;

  localparam logic [15:0] READ_LENGTH_RESET = 16'd150;

  logic [15:0] read_length;
  fbnp_item_t  item;
  logic        advance;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      read_length <= READ_LENGTH_RESET;
    end else if (cfg_write_en) begin
      read_length <= cfg_write_data;
    end
  end

  fbnp_in_stage u_in_stage (
    .clk     (clk),
    .rst     (rst),
    .in_ch   (in_ch),
    .advance (advance),
    .item    (item)
  );

  fbnp_parser #(
    .MAX_READ_LEN (MAX_READ_LEN)
  ) u_parser (
    .clk         (clk),
    .rst         (rst),
    .item        (item),
    .read_length (read_length),
    .advance     (advance),
    .out_ch      (out_ch)
  );

endmodule

### rtl/core/fbnp_in_stage.sv
// Input register of the FASTQ base nibble packer.
// Depends on fbnp_pkg and fbnp_in_if.
module fbnp_in_stage (
  input  logic               clk,
  input  logic               rst,
  fbnp_in_if.sink            in_ch,
  input  logic               advance,
  output fbnp_pkg::fbnp_item_t item
);
  import fbnp_pkg::*;

  // The register takes a new item whenever it is empty or its item moves on.
  assign in_ch.ready = !item.valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      item.valid <= 1'b0;
    end else if (in_ch.ready) begin
      item.valid <= in_ch.valid;
    end
    if (in_ch.valid && in_ch.ready) begin
      item.data <= in_ch.in_byte;
    end
  end

endmodule

### rtl/core/fbnp_parser.sv
// Record parser and nibble packer with its result register.
// Depends on fbnp_pkg and fbnp_out_if.
module fbnp_parser #(
  parameter int MAX_READ_LEN = 65535
) (
  input  logic                 clk,
  input  logic                 rst,
  input  fbnp_pkg::fbnp_item_t item,
  input  logic [15:0]          read_length,
  output logic                 advance,
  fbnp_out_if.source           out_ch
);
  import fbnp_pkg::*;

  localparam int CNT_W = $clog2(MAX_READ_LEN + 2);
  localparam logic [CNT_W-1:0] MAX_LEN = CNT_W'(MAX_READ_LEN);

  logic [2:0]       phase;
  logic [2:0]       phase_next;
  logic [CNT_W-1:0] byte_count;
  logic [CNT_W-1:0] byte_count_next;
  logic [2:0]       held_code;
  logic [2:0]       held_code_next;

  logic [CNT_W-1:0] eff_len;
  logic [CNT_W-1:0] count_inc;
  logic [2:0]       code;
  logic             emit;
  logic [7:0]       emit_byte;
  logic             emit_last;
  logic             step;

  // The item moves on when the result register is empty or being drained.
  assign advance = !out_ch.valid || out_ch.ready;
  assign step    = item.valid && advance;

  // Effective read length: zero acts as one, clamped to the maximum.
  always_comb begin
    if (read_length == 16'd0) begin
      eff_len = CNT_W'(1);
    end else if (32'(read_length) > 32'(MAX_READ_LEN)) begin
      eff_len = MAX_LEN;
    end else begin
      eff_len = CNT_W'(read_length);
    end
  end

  assign count_inc = byte_count + CNT_W'(1);
  assign code      = base_code(item.data);

  // Next state and result for the current item.
  always_comb begin
    phase_next      = phase;
    byte_count_next = byte_count;
    held_code_next  = held_code;
    emit            = 1'b0;
    emit_byte       = {5'd0, held_code};
    emit_last       = 1'b0;
    case (phase)
      PH_SEQ: begin
        byte_count_next = count_inc;
        if (!byte_count[0]) begin
          // First base of a pair is held; it goes out alone if it ends the read.
          held_code_next = code;
          emit_byte      = {5'd0, code};
          emit           = count_inc >= eff_len;
        end else begin
          emit      = 1'b1;
          emit_byte = {1'b0, code, 1'b0, held_code};
        end
        emit_last = count_inc >= eff_len;
        if (count_inc >= eff_len) begin
          phase_next      = PH_SEPNL;
          byte_count_next = '0;
        end
      end
      PH_SEPNL: begin
        phase_next = PH_PLUS;
      end
      PH_PLUS: begin
        if (item.data == NEWLINE) begin
          phase_next      = PH_QUAL;
          byte_count_next = '0;
        end
      end
      PH_QUAL: begin
        // Quality bytes and their newline are counted, not scanned.
        byte_count_next = count_inc;
        if (count_inc >= eff_len + CNT_W'(1)) begin
          phase_next      = PH_HEADER;
          byte_count_next = '0;
        end
      end
      default: begin
        phase_next = PH_HEADER;
        if (item.data == NEWLINE) begin
          phase_next      = PH_SEQ;
          byte_count_next = '0;
          held_code_next  = 3'd0;
        end
      end
    endcase
  end

  // Parser state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_HEADER;
      byte_count <= '0;
      held_code  <= 3'd0;
    end else if (step) begin
      phase      <= phase_next;
      byte_count <= byte_count_next;
      held_code  <= held_code_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
    end else if (advance) begin
      out_ch.valid <= step && emit;
    end
    if (step && emit) begin
      out_ch.packed_byte  <= emit_byte;
      out_ch.last_of_read <= emit_last;
    end
  end

endmodule

### verif/tb_fastq_base_nibble_packer_core.sv
// Self-checking testbench for fastq_base_nibble_packer_core: FASTQ text in,
// packed base nibbles out, checked against a cycle-free parser model.
// Depends on fbnp_pkg, fbnp_if and the packer RTL.
`timescale 1ns / 1ps

module tb_fastq_base_nibble_packer_core;
  import fbnp_pkg::*;

  localparam int unsigned RANDOM_ITEMS = 1950;
  localparam int unsigned SETTLE_CYCLES = 6;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned LONG_HOLD_CYCLES = 300;

  // Base codes as the packer emits them.
  localparam logic [2:0] BASE_A = 3'd0;
  localparam logic [2:0] BASE_C = 3'd1;
  localparam logic [2:0] BASE_G = 3'd2;
  localparam logic [2:0] BASE_T = 3'd3;

  // Receiver stall patterns.
  typedef enum logic [1:0] {
    READY_ALWAYS,
    READY_THREE_OF_FOUR,
    READY_COIN_FLIP,
    READY_ONE_OF_FIVE
  } ready_pattern_e;

  // One packed output byte as the parser should produce it.
  typedef struct packed {
    logic [7:0] packed_byte;
    logic       last_of_read;
  } nibble_pair_t;

  logic        clk;
  logic        rst;
  logic        cfg_write_en;
  logic [15:0] cfg_write_data;

  fbnp_in_if  in_ch ();
  fbnp_out_if out_ch ();

  fastq_base_nibble_packer_core u_dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data),
    .in_ch          (in_ch),
    .out_ch         (out_ch)
  );

  // Text bytes waiting to be sent, and packed bytes waiting to come back.
  logic [7:0]   text_q[$];
  nibble_pair_t pair_expect_q[$];

  // Parser state, mirrored from the block.
  logic [15:0] read_len;
  logic [2:0]  parse_phase;
  logic [16:0] base_idx;
  logic [2:0]  held_base;

  int unsigned    mismatches;
  int unsigned    text_sent;
  int unsigned    cycle_cnt;
  logic           stress_go;
  int unsigned    burst_left;
  int unsigned    gap_left;
  int unsigned    hold_left;
  int unsigned    holds_done;
  logic [7:0]     pat_cnt;
  ready_pattern_e pat_mode;
  logic           ready_now;
  nibble_pair_t   want;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Map one text byte to its base code; letters are folded to lower case.
  function automatic logic [2:0] nucleotide_code(input logic [7:0] b);
    logic [2:0] code;
    if (b < 8'd4) begin
      code = b[2:0];
    end else begin
      case (b | 8'h20)
        "a":      code = BASE_A;
        "c":      code = BASE_C;
        "g":      code = BASE_G;
        "t", "u": code = BASE_T;
        default:  code = CODE_OTHER;
      endcase
    end
    return code;
  endfunction

  // Advance the parser by one text byte and queue any packed byte it yields.
  task automatic parse_byte(input logic [7:0] b);
    logic [16:0]  lim;
    logic [2:0]   code;
    logic         first_of_pair;
    logic         seq_done;
    nibble_pair_t res;
    lim = (read_len == 16'd0) ? 17'd1 : {1'b0, read_len};
    case (parse_phase)
      PH_SEQ: begin
        code = nucleotide_code(b);
        first_of_pair = !base_idx[0];
        base_idx = base_idx + 17'd1;
        seq_done = (base_idx >= lim);
        if (first_of_pair) begin
          held_base = code;
          if (seq_done) begin
            res.packed_byte = {5'd0, held_base};
            res.last_of_read = 1'b1;
            pair_expect_q.push_back(res);
          end
        end else begin
          res.packed_byte = {1'b0, code, 1'b0, held_base};
          res.last_of_read = seq_done;
          pair_expect_q.push_back(res);
        end
        if (seq_done) begin
          parse_phase = PH_SEPNL;
          base_idx = '0;
        end
      end
      PH_SEPNL: parse_phase = PH_PLUS;
      PH_PLUS: begin
        if (b == NEWLINE) begin
          parse_phase = PH_QUAL;
          base_idx = '0;
        end
      end
      PH_QUAL: begin
        base_idx = base_idx + 17'd1;
        if (base_idx >= lim + 17'd1) begin
          parse_phase = PH_HEADER;
          base_idx = '0;
        end
      end
      default: begin
        parse_phase = PH_HEADER;
        if (b == NEWLINE) begin
          parse_phase = PH_SEQ;
          base_idx = '0;
          held_base = '0;
        end
      end
    endcase
  endtask

  // Sender: bursts of random length separated by random gaps.
  always @(posedge clk) begin
    if (rst) begin
      in_ch.valid <= 1'b0;
      in_ch.in_byte <= 8'd0;
      burst_left <= 0;
      gap_left <= 0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (gap_left != 0) begin
        gap_left <= gap_left - 1;
        in_ch.valid <= 1'b0;
      end else if (text_q.size() != 0) begin
        in_ch.valid <= 1'b1;
        in_ch.in_byte <= text_q.pop_front();
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 48);
          gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Long receiver hold-off while the sender keeps offering text.
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
      holds_done <= 0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (stress_go && holds_done < 2 && text_q.size() > 100) begin
      hold_left <= LONG_HOLD_CYCLES;
      holds_done <= holds_done + 1;
    end
  end

  // Receiver: picks a stall pattern at random each time the 8-bit pattern counter wraps.
  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
      pat_cnt <= 8'd0;
      pat_mode <= READY_ALWAYS;
    end else begin
      pat_cnt <= pat_cnt + 8'd1;
      if (pat_cnt == 8'hFF) pat_mode <= ready_pattern_e'($urandom_range(0, 3));
      case (pat_mode)
        READY_THREE_OF_FOUR: ready_now = (pat_cnt[1:0] != 2'd0);
        READY_COIN_FLIP:     ready_now = ($urandom_range(0, 1) == 1);
        READY_ONE_OF_FIVE:   ready_now = (pat_cnt % 5 == 0);
        default:             ready_now = 1'b1;
      endcase
      out_ch.ready <= ready_now && (hold_left == 0);
    end
  end

  // Check each packed byte against the oldest expectation, then feed the
  // parser with the text byte accepted at this edge.
  always @(posedge clk) begin
    if (!rst) begin
      if (out_ch.valid && out_ch.ready) begin
        if (pair_expect_q.size() == 0) begin
          $error("unexpected item: packed_byte %02h last_of_read %0b",
                 out_ch.packed_byte, out_ch.last_of_read);
          mismatches++;
        end else begin
          want = pair_expect_q.pop_front();
          if (out_ch.packed_byte !== want.packed_byte) begin
            $error("packed_byte: expected %02h, got %02h",
                   want.packed_byte, out_ch.packed_byte);
            mismatches++;
          end
          if (out_ch.last_of_read !== want.last_of_read) begin
            $error("last_of_read: expected %0b, got %0b",
                   want.last_of_read, out_ch.last_of_read);
            mismatches++;
          end
        end
      end
      if (in_ch.valid && in_ch.ready) parse_byte(in_ch.in_byte);
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("tb_fastq_base_nibble_packer_core NOT OK");
      $finish;
    end
  end

  task automatic push_byte(input logic [7:0] b);
    text_q.push_back(b);
    text_sent++;
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) push_byte(s[i]);
  endtask

  // Any byte but a newline, for header and separator lines.
  function automatic logic [7:0] line_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255)); while (b == NEWLINE);
    return b;
  endfunction

  // Mostly real bases in either case, sometimes raw codes or junk.
  function automatic logic [7:0] seq_byte();
    logic [7:0] b;
    case ($urandom_range(0, 17))
      0: b = "A";
      1: b = "a";
      2: b = "C";
      3: b = "c";
      4: b = "G";
      5: b = "g";
      6: b = "T";
      7: b = "t";
      8: b = "U";
      9: b = "u";
      10, 11, 12: b = 8'($urandom_range(0, 3));
      default: b = 8'($urandom_range(0, 255));
    endcase
    return b;
  endfunction

  // One FASTQ record with the given number of bases and quality bytes.
  task automatic push_record(input int unsigned n_bases);
    push_byte("@");
    repeat ($urandom_range(0, 6)) push_byte(line_byte());
    push_byte(NEWLINE);
    repeat (n_bases) push_byte(seq_byte());
    push_byte(($urandom_range(0, 7) == 0) ? line_byte() : NEWLINE);
    push_byte("+");
    repeat ($urandom_range(0, 3)) push_byte(line_byte());
    push_byte(NEWLINE);
    repeat (n_bases) push_byte(8'($urandom_range(0, 255)));
    push_byte(NEWLINE);
  endtask

  // Wait until all text is sent and every packed byte has come back, then
  // give the pipeline time to finish any byte that yields nothing.
  task automatic wait_quiet();
    while (text_q.size() != 0 || in_ch.valid || pair_expect_q.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_read_length(input logic [15:0] len);
    @(posedge clk);
    cfg_write_en <= 1'b1;
    cfg_write_data <= len;
    read_len = len;
    @(posedge clk);
    cfg_write_en <= 1'b0;
    @(negedge clk);
  endtask

  initial begin
    logic [15:0] new_len;
    int unsigned bases;
    rst = 1'b1;
    cfg_write_en = 1'b0;
    cfg_write_data = 16'd0;
    in_ch.valid = 1'b0;
    in_ch.in_byte = 8'd0;
    out_ch.ready = 1'b0;
    read_len = 16'd150;
    parse_phase = PH_HEADER;
    base_idx = '0;
    held_base = '0;
    mismatches = 0;
    text_sent = 0;
    cycle_cnt = 0;
    stress_go = 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Reset length in force: pairs go out unflagged. Then the length shrinks
    // below the count already reached, so the next base ends the read alone.
    push_text("\nACGT");
    wait_quiet();
    set_read_length(16'd3);
    push_text("g\n+x\nIIII");

    // Zero length acts as one; an unknown base codes as other, and the byte
    // after the sequence is consumed whatever it is.
    wait_quiet();
    set_read_length(16'd0);
    push_byte(NEWLINE);
    push_byte(8'hFF);
    push_text("Z+\n!\n");

    // Longest length with raw codes, cut short mid-sequence, then shortened
    // again partway through the quality bytes.
    wait_quiet();
    set_read_length(16'hFFFF);
    push_text("@\nUu");
    push_byte(8'd0);
    push_byte(8'd1);
    push_byte(8'd2);
    push_byte(8'd3);
    push_byte("c");
    wait_quiet();
    set_read_length(16'd2);
    push_text("t\n+\n#");
    wait_quiet();
    set_read_length(16'd1);
    push_text("#");

    // Random records, mostly well formed; a long first batch feeds the hold-off.
    wait_quiet();
    text_sent = 0;
    stress_go = 1'b1;
    set_read_length(16'd150);
    repeat (3) push_record(150);
    while (text_sent < RANDOM_ITEMS) begin
      wait_quiet();
      case ($urandom_range(0, 15))
        0: new_len = 16'd0;
        1: new_len = 16'($urandom_range(30, 80));
        default: new_len = 16'($urandom_range(1, 10));
      endcase
      set_read_length(new_len);
      bases = (new_len == 16'd0) ? 1 : new_len;
      repeat ($urandom_range(1, 4)) begin
        case ($urandom_range(0, 9))
          0: repeat ($urandom_range(1, 20)) push_byte(8'($urandom_range(0, 255)));
          1: push_record($urandom_range(1, bases + 3));
          default: push_record(bases);
        endcase
      end
      // Sometimes leave a read half done so the next length lands mid-record.
      if ($urandom_range(0, 5) == 0) begin
        push_byte("@");
        push_byte(NEWLINE);
        repeat ($urandom_range(1, bases)) push_byte(seq_byte());
      end
    end

    wait_quiet();
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb_fastq_base_nibble_packer_core OK");
    end else begin
      $display("tb_fastq_base_nibble_packer_core NOT OK");
    end
    $finish;
  end

endmodule
